@@ hdl/bilinear_grid_regrid_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the regridding block
// Shared concurrent assertion forms, clocked on clock and held off in reset.
// ----------------------------------------------------------------------------
`ifndef BILINEAR_GRID_REGRID_ASSERT_SVH
`define BILINEAR_GRID_REGRID_ASSERT_SVH

// consequence must hold in the same cycle as the antecedent
`define BGR_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bgr assertion failed");

// consequence must hold in the cycle after the antecedent
`define BGR_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bgr assertion failed");

`endif

@@ hdl/bgr_pkg.sv @@
// ----------------------------------------------------------------------------
// Regridding block package
// Sizes, shared types and helper functions of the bilinear regridder.
// ----------------------------------------------------------------------------
package bgr_pkg;

   localparam int MAX_COLS    = 1024;
   localparam int MAX_ROWS    = 512;
   localparam int FRAC_BITS   = 12;
   localparam int SAMPLE_BITS = 32;

   // field widths
   localparam int VAL_W   = 32;
   localparam int COORD_W = 24;
   localparam int LCOL_W  = 10;
   localparam int LROW_W  = 9;
   localparam int GCOLS_W = 11;
   localparam int GROWS_W = 10;
   localparam int CSR_W   = 2;

   // store geometry
   localparam int COL_W  = $clog2(MAX_COLS);
   localparam int ROW_W  = $clog2(MAX_ROWS);
   localparam int DEPTH  = MAX_COLS * MAX_ROWS;
   localparam int ADDR_W = $clog2(DEPTH);

   // arithmetic widths
   localparam int ONE    = 1 << FRAC_BITS;
   localparam int FR_W   = FRAC_BITS + 1;
   localparam int WGT_W  = 2 * FRAC_BITS + 1;
   localparam int PROD_W = VAL_W + WGT_W + 1;
   localparam int ACC_W  = PROD_W + 2;
   localparam int DCNT_W = $clog2(ACC_W + 1);
   localparam int CW     = ((COORD_W > GCOLS_W + FRAC_BITS) ? COORD_W
                                                            : GCOLS_W + FRAC_BITS) + 2;
   localparam int IW     = CW - FRAC_BITS;
   localparam int KEEP_W = (SAMPLE_BITS < VAL_W) ? SAMPLE_BITS : VAL_W;

   localparam logic [WGT_W-1:0] WGT_FULL = WGT_W'(1) << (2 * FRAC_BITS);

   // corner offsets, corner k of a cell
   localparam logic [3:0] CORNER_DX = 4'b1010;
   localparam logic [3:0] CORNER_DY = 4'b1100;

   typedef enum logic [CSR_W-1:0] {
      CSR_GRID_COLS   = 2'd0,
      CSR_GRID_ROWS   = 2'd1,
      CSR_INTERP_MODE = 2'd2,
      CSR_MISSING     = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [GCOLS_W-1:0] cols;
      logic [GROWS_W-1:0] rows;
      logic               masked;
      logic [VAL_W-1:0]   missing;
   } cfg_type;

   // one classified item between front and back
   typedef struct packed {
      logic             is_query;
      logic             masked;
      logic             in_grid;
      logic             load_ok;
      logic [COL_W-1:0] c0;
      logic [COL_W-1:0] c1;
      logic [ROW_W-1:0] r0;
      logic [ROW_W-1:0] r1;
      logic [FR_W-1:0]  fx;
      logic [FR_W-1:0]  fy;
      logic [VAL_W-1:0] sample;
   } entry_type;

   // keep the low sample bits, sign extended
   function automatic logic [VAL_W-1:0] keep_sample(input logic [VAL_W-1:0] v);
      logic [VAL_W-1:0] r;
      for (int i = 0; i < VAL_W; i++) begin
         r[i] = (i < KEEP_W) ? v[i] : v[KEEP_W-1];
      end
      return r;
   endfunction

   // saturate a sign and magnitude pair to a signed sample
   function automatic logic [VAL_W-1:0] sat_value(input logic neg,
                                                  input logic [ACC_W-1:0] q);
      logic [ACC_W-1:0] pos_lim;
      logic [ACC_W-1:0] neg_lim;
      logic [ACC_W-1:0] nq;
      pos_lim = {{(ACC_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
      neg_lim = pos_lim + ACC_W'(1);
      nq      = ACC_W'(0) - q;
      if (neg) begin
         return (q > neg_lim) ? {1'b1, {(VAL_W-1){1'b0}}} : nq[VAL_W-1:0];
      end
      return (q > pos_lim) ? pos_lim[VAL_W-1:0] : q[VAL_W-1:0];
   endfunction

endpackage

@@ hdl/bilinear_grid_regrid.sv @@
// ----------------------------------------------------------------------------
// Bilinear grid regridder
// Loads a source grid and answers bilinear queries in halo or masked mode.
// ----------------------------------------------------------------------------
// A load request (req_type 0) writes one sample in the back end; a query
// (req_type 1) returns exactly one result on rsp_valid, which must be taken
// in the cycle it is shown. In halo mode the single read port of the grid
// store reads one corner per cycle, so a query holds the port for all four
// of its corners before the next query starts. In masked mode one query is
// in the back end at a time, and a query whose weights are renormalised
// also waits for the one bit per cycle divider. The store has no clearing
// pass; reading a never-written entry yields an unspecified value.
// Registers must be written through csr_ only while the block is idle;
// the block itself does not enforce this.
// ----------------------------------------------------------------------------
module bilinear_grid_regrid (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_type,
   input  logic [bgr_pkg::LCOL_W-1:0]          req_load_col,
   input  logic [bgr_pkg::LROW_W-1:0]          req_load_row,
   input  logic signed [bgr_pkg::VAL_W-1:0]    req_sample_value,
   input  logic signed [bgr_pkg::COORD_W-1:0]  req_coord_x,
   input  logic signed [bgr_pkg::COORD_W-1:0]  req_coord_y,
   output logic                                rsp_valid,
   output logic signed [bgr_pkg::VAL_W-1:0]    rsp_result_value,
   output logic                                rsp_is_missing,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bgr_pkg::CSR_W-1:0]           csr_index,
   input  logic [bgr_pkg::VAL_W-1:0]           csr_data
);
   import bgr_pkg::*;

   logic [GCOLS_W-1:0] cols_ff, cols_in;
   logic [GROWS_W-1:0] rows_ff, rows_in;
   logic               mode_ff, mode_in;
   logic [VAL_W-1:0]   miss_ff, miss_in;
   cfg_type            cfg;
   logic               q_full, q_push, q_pop, head_valid;
   entry_type          q_data, head;

   assign csr_ready = 1'b1;

   // register writes
   always_comb begin
      cols_in = cols_ff;
      rows_in = rows_ff;
      mode_in = mode_ff;
      miss_in = miss_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_GRID_COLS:   cols_in = csr_data[GCOLS_W-1:0];
            CSR_GRID_ROWS:   rows_in = csr_data[GROWS_W-1:0];
            CSR_INTERP_MODE: mode_in = csr_data[0];
            CSR_MISSING:     miss_in = csr_data;
            default:         cols_in = cols_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= GCOLS_W'(1024);
         rows_ff <= GROWS_W'(512);
         mode_ff <= 1'b0;
         miss_ff <= '0;
      end else begin
         cols_ff <= cols_in;
         rows_ff <= rows_in;
         mode_ff <= mode_in;
         miss_ff <= miss_in;
      end
   end

   // grid dimensions saturated to the store size, zero taken as one
   always_comb begin
      cfg.cols    = (cols_ff == '0) ? GCOLS_W'(1) :
                    ((32'(cols_ff) > MAX_COLS) ? GCOLS_W'(MAX_COLS) : cols_ff);
      cfg.rows    = (rows_ff == '0) ? GROWS_W'(1) :
                    ((32'(rows_ff) > MAX_ROWS) ? GROWS_W'(MAX_ROWS) : rows_ff);
      cfg.masked  = mode_ff;
      cfg.missing = miss_ff;
   end

   bgr_front u_front (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_type         (req_type),
      .req_load_col     (req_load_col),
      .req_load_row     (req_load_row),
      .req_sample_value (req_sample_value),
      .req_coord_x      (req_coord_x),
      .req_coord_y      (req_coord_y),
      .cfg              (cfg),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_data           (q_data)
   );

   bgr_fifo u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_data),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (head_valid),
      .head_data  (head)
   );

   bgr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head        (head),
      .pop         (q_pop),
      .missing     (cfg.missing),
      .rsp_valid   (rsp_valid),
      .rsp_value   (rsp_result_value),
      .rsp_missing (rsp_is_missing)
   );

endmodule

@@ hdl/bgr_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bgr_ram #(
   parameter int WIDTH = 32,
   parameter int WORDS = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(WORDS)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(WORDS)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [WORDS];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/bgr_front.sv @@
// ----------------------------------------------------------------------------
// Regridder front end
// Takes requests, splits coordinates into cell and fraction, resolves
// halo wrap and clamp, and hands classified items to the queue.
// ----------------------------------------------------------------------------
module bgr_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_type,
   input  logic [bgr_pkg::LCOL_W-1:0]       req_load_col,
   input  logic [bgr_pkg::LROW_W-1:0]       req_load_row,
   input  logic signed [bgr_pkg::VAL_W-1:0] req_sample_value,
   input  logic signed [bgr_pkg::COORD_W-1:0] req_coord_x,
   input  logic signed [bgr_pkg::COORD_W-1:0] req_coord_y,
   input  bgr_pkg::cfg_type                 cfg,
   input  logic                             q_full,
   output logic                             q_push,
   output bgr_pkg::entry_type               q_data
);
   import bgr_pkg::*;

   logic                 hold_valid_ff, hold_valid_in;
   entry_type            hold_data_ff, hold_data_in;
   entry_type            cls;
   logic                 accept;

   logic signed [CW-1:0] xs, ys, xc, yc, one_s, xhi, yhi;
   logic signed [IW-1:0] ix, iy, cols_i, rows_i;
   logic [FR_W-1:0]      fx, fy;

   assign busy   = hold_valid_ff & q_full;
   assign accept = start & ~busy;
   assign q_push = hold_valid_ff & ~q_full;
   assign q_data = hold_data_ff;

   // classification of the incoming request
   always_comb begin
      one_s  = CW'(ONE);
      xs     = CW'(req_coord_x);
      ys     = CW'(req_coord_y);
      cols_i = IW'({1'b0, cfg.cols});
      rows_i = IW'({1'b0, cfg.rows});
      xhi    = CW'({1'b0, cfg.cols}) <<< FRAC_BITS;
      yhi    = CW'({1'b0, cfg.rows}) <<< FRAC_BITS;

      // halo clamps the coordinates to one cell beyond the grid
      if (cfg.masked) begin
         xc = xs;
         yc = ys;
      end else begin
         xc = (xs < -one_s) ? -one_s : ((xs > xhi) ? xhi : xs);
         yc = (ys < -one_s) ? -one_s : ((ys > yhi) ? yhi : ys);
      end

      ix = xc[CW-1:FRAC_BITS];
      iy = yc[CW-1:FRAC_BITS];
      fx = {1'b0, xc[FRAC_BITS-1:0]};
      fy = {1'b0, yc[FRAC_BITS-1:0]};

      // upper edge: the cell below, full weight on its upper corner
      if (!cfg.masked && ix >= cols_i) begin
         ix = cols_i - IW'(1);
         fx = FR_W'(ONE);
      end
      if (!cfg.masked && iy >= rows_i) begin
         iy = rows_i - IW'(1);
         fy = FR_W'(ONE);
      end

      cls          = '0;
      cls.is_query = req_type;
      cls.masked   = cfg.masked;
      cls.sample   = keep_sample(req_sample_value);
      cls.load_ok  = (32'(req_load_col) < MAX_COLS) && (32'(req_load_row) < MAX_ROWS);
      cls.fx       = fx;
      cls.fy       = fy;
      cls.in_grid  = (ix >= IW'(0)) && (ix + IW'(1) < cols_i) &&
                     (iy >= IW'(0)) && (iy + IW'(1) < rows_i);

      if (!req_type) begin
         cls.c0 = COL_W'(req_load_col);
         cls.c1 = COL_W'(req_load_col);
         cls.r0 = ROW_W'(req_load_row);
         cls.r1 = ROW_W'(req_load_row);
      end else if (cfg.masked) begin
         cls.c0 = ix[COL_W-1:0];
         cls.c1 = COL_W'(ix + IW'(1));
         cls.r0 = iy[ROW_W-1:0];
         cls.r1 = ROW_W'(iy + IW'(1));
      end else begin
         // columns wrap, rows clamp
         cls.c0 = (ix < IW'(0)) ? COL_W'(cols_i - IW'(1)) : ix[COL_W-1:0];
         cls.c1 = (ix + IW'(1) >= cols_i) ? COL_W'(ix + IW'(1) - cols_i)
                                          : COL_W'(ix + IW'(1));
         cls.r0 = (iy < IW'(0)) ? ROW_W'(0) : iy[ROW_W-1:0];
         cls.r1 = (iy + IW'(1) >= rows_i) ? ROW_W'(rows_i - IW'(1))
                                          : ROW_W'(iy + IW'(1));
      end
   end

   // holding stage in front of the queue
   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_data_in  = hold_data_ff;
      if (q_push) begin
         hold_valid_in = 1'b0;
      end
      if (accept) begin
         hold_valid_in = 1'b1;
         hold_data_in  = cls;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
      hold_data_ff <= hold_data_in;
   end

endmodule

@@ hdl/bgr_fifo.sv @@
// ----------------------------------------------------------------------------
// Item queue
// Short queue of classified items between front and back end.
// ----------------------------------------------------------------------------
module bgr_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  bgr_pkg::entry_type push_data,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output bgr_pkg::entry_type head_data
);
   import bgr_pkg::*;

   localparam int QD = 4;
   localparam int PW = $clog2(QD);

   entry_type     slot_ff [QD];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PW:0]   count_ff, count_in;

   assign full       = (count_ff == (PW+1)'(QD));
   assign head_valid = (count_ff != '0);
   assign head_data  = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff + (PW+1)'(push) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ hdl/bgr_back.sv @@
// ----------------------------------------------------------------------------
// Regridder back end
// Writes loaded samples, reads the four corners of each query one per
// cycle, weights and sums them, then rounds or renormalises the sum, or reports missing when no corner survives.
// ----------------------------------------------------------------------------
`include "bilinear_grid_regrid_assert.svh"

module bgr_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     head_valid,
   input  bgr_pkg::entry_type       head,
   output logic                     pop,
   input  logic [bgr_pkg::VAL_W-1:0] missing,
   output logic                     rsp_valid,
   output logic [bgr_pkg::VAL_W-1:0] rsp_value,
   output logic                     rsp_missing
);
   import bgr_pkg::*;

   // issue stage
   logic [1:0]        cnt_ff, cnt_in;
   logic              pend_ff, pend_in;
   logic              issue, do_load;
   logic              dx, dy;
   logic [COL_W-1:0]  rc;
   logic [ROW_W-1:0]  rr;
   logic [ADDR_W-1:0] rd_addr, wr_addr;
   logic [FR_W-1:0]   wa, wb;
   logic [2*FR_W-1:0] wprod;
   logic [VAL_W-1:0]  rd_data;

   // read stage
   logic              s1_valid_ff, s1_first_ff, s1_last_ff, s1_masked_ff, s1_inside_ff;
   logic [WGT_W-1:0]  s1_wgt_ff;
   logic              keep;
   logic signed [PROD_W-1:0] prod;

   // product stage
   logic              s2_valid_ff, s2_first_ff, s2_last_ff, s2_masked_ff;
   logic signed [PROD_W-1:0] s2_prod_ff;
   logic [WGT_W-1:0]  s2_wgt_ff;

   // sum stage
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic [WGT_W-1:0]  wsum_ff, wsum_in;
   logic              s3_valid_ff, s3_masked_ff;

   // finish and divider
   logic              neg;
   logic [ACC_W-1:0]  mag, shq;
   logic              dv_start, dv_done;
   logic              dv_busy_ff, dv_busy_in, dv_neg_ff, dv_neg_in;
   logic [ACC_W-1:0]  dv_num_ff, dv_num_in;
   logic [WGT_W-1:0]  dv_rem_ff, dv_rem_in, dv_den_ff, dv_den_in;
   logic [DCNT_W-1:0] dv_cnt_ff, dv_cnt_in;
   logic [WGT_W:0]    trial;
   logic              ge, dv_rnd;

   logic              out_v_in, out_m_in;
   logic [VAL_W-1:0]  out_d_in;
   logic              rsp_valid_ff, rsp_missing_ff;
   logic [VAL_W-1:0]  rsp_value_ff;

   // issue: one corner read per cycle, a masked query waits until the previous masked query has its result
   always_comb begin
      do_load = head_valid & ~head.is_query;
      issue   = head_valid & head.is_query &
                ((cnt_ff != 2'd0) | ~(head.masked & pend_ff));
      pop     = do_load | (issue & (cnt_ff == 2'd3));
      cnt_in  = issue ? cnt_ff + 2'd1 : cnt_ff;
      dx      = CORNER_DX[cnt_ff];
      dy      = CORNER_DY[cnt_ff];
      rc      = dx ? head.c1 : head.c0;
      rr      = dy ? head.r1 : head.r0;
      rd_addr = ADDR_W'(rr) * ADDR_W'(MAX_COLS) + ADDR_W'(rc);
      wr_addr = ADDR_W'(head.r0) * ADDR_W'(MAX_COLS) + ADDR_W'(head.c0);
      wa      = dx ? head.fx : FR_W'(ONE) - head.fx;
      wb      = dy ? head.fy : FR_W'(ONE) - head.fy;
      wprod   = (2*FR_W)'(wa) * (2*FR_W)'(wb);
   end

   bgr_ram #(
      .WIDTH (VAL_W),
      .WORDS (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (do_load & head.load_ok),
      .wr_addr (wr_addr),
      .wr_data (head.sample),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // weighting of the corner sample; in masked mode missing samples and queries outside the grid are dropped
   always_comb begin
      keep = ~s1_masked_ff |
             (s1_inside_ff & ((missing == '0) | (rd_data != missing)));
      prod = PROD_W'($signed(rd_data)) * PROD_W'($signed({1'b0, s1_wgt_ff}));
   end

   // running sum over the four corners
   always_comb begin
      acc_in  = acc_ff;
      wsum_in = wsum_ff;
      if (s2_valid_ff) begin
         acc_in  = (s2_first_ff ? ACC_W'(0) : acc_ff) + ACC_W'(s2_prod_ff);
         wsum_in = (s2_first_ff ? WGT_W'(0) : wsum_ff) + s2_wgt_ff;
      end
   end

   // rounding by shift when the weight is whole
   always_comb begin
      neg = acc_ff[ACC_W-1];
      mag = neg ? ACC_W'(0) - acc_ff : acc_ff;
      shq = (mag >> (2 * FRAC_BITS)) + ACC_W'(mag[2*FRAC_BITS-1]);
      dv_start = s3_valid_ff & s3_masked_ff & (wsum_ff != '0) & (wsum_ff != WGT_FULL);
   end

   // restoring divider, one quotient bit per cycle
   always_comb begin
      trial      = {dv_rem_ff, dv_num_ff[ACC_W-1]};
      ge         = trial >= {1'b0, dv_den_ff};
      dv_done    = dv_busy_ff & (dv_cnt_ff == '0);
      dv_rnd     = {dv_rem_ff, 1'b0} >= {1'b0, dv_den_ff};
      dv_busy_in = dv_busy_ff;
      dv_neg_in  = dv_neg_ff;
      dv_num_in  = dv_num_ff;
      dv_rem_in  = dv_rem_ff;
      dv_den_in  = dv_den_ff;
      dv_cnt_in  = dv_cnt_ff;
      if (dv_start) begin
         dv_busy_in = 1'b1;
         dv_neg_in  = neg;
         dv_num_in  = mag;
         dv_rem_in  = '0;
         dv_den_in  = wsum_ff;
         dv_cnt_in  = DCNT_W'(ACC_W);
      end else if (dv_done) begin
         dv_busy_in = 1'b0;
      end else if (dv_busy_ff) begin
         dv_num_in  = {dv_num_ff[ACC_W-2:0], ge};
         dv_rem_in  = ge ? WGT_W'(trial - {1'b0, dv_den_ff}) : WGT_W'(trial);
         dv_cnt_in  = dv_cnt_ff - DCNT_W'(1);
      end
   end

   // result selection and masked query tracking
   always_comb begin
      out_v_in = 1'b0;
      out_m_in = 1'b0;
      out_d_in = '0;
      if (dv_done) begin
         out_v_in = 1'b1;
         out_d_in = sat_value(dv_neg_ff, dv_num_ff + ACC_W'(dv_rnd));
      end else if (s3_valid_ff) begin
         if (s3_masked_ff && wsum_ff == '0) begin
            out_v_in = 1'b1;
            out_m_in = 1'b1;
            out_d_in = missing;
         end else if (!dv_start) begin
            out_v_in = 1'b1;
            out_d_in = sat_value(neg, shq);
         end
      end
      pend_in = pend_ff;
      if (issue && cnt_ff == 2'd0 && head.masked) begin
         pend_in = 1'b1;
      end else if (dv_done || (s3_valid_ff && s3_masked_ff && !dv_start)) begin
         pend_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         dv_busy_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         s1_valid_ff  <= issue;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff & s2_last_ff;
         dv_busy_ff   <= dv_busy_in;
         rsp_valid_ff <= out_v_in;
      end
      s1_first_ff    <= (cnt_ff == 2'd0);
      s1_last_ff     <= (cnt_ff == 2'd3);
      s1_masked_ff   <= head.masked;
      s1_inside_ff   <= head.in_grid;
      s1_wgt_ff      <= wprod[WGT_W-1:0];
      s2_first_ff    <= s1_first_ff;
      s2_last_ff     <= s1_last_ff;
      s2_masked_ff   <= s1_masked_ff;
      s2_prod_ff     <= keep ? prod : PROD_W'(0);
      s2_wgt_ff      <= keep ? s1_wgt_ff : WGT_W'(0);
      s3_masked_ff   <= s2_masked_ff;
      acc_ff         <= acc_in;
      wsum_ff        <= wsum_in;
      dv_neg_ff      <= dv_neg_in;
      dv_num_ff      <= dv_num_in;
      dv_rem_ff      <= dv_rem_in;
      dv_den_ff      <= dv_den_in;
      dv_cnt_ff      <= dv_cnt_in;
      rsp_value_ff   <= out_d_in;
      rsp_missing_ff <= out_m_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_value   = rsp_value_ff;
   assign rsp_missing = rsp_missing_ff;

   // corners of one query are issued back to back from the same head item
   `BGR_ASSERT_SAME(a_corner_head, cnt_ff != 2'd0, head_valid && head.is_query)
   // a masked sum never reaches the finisher while the divider is busy
   `BGR_ASSERT_SAME(a_div_free, s3_valid_ff && s3_masked_ff, !dv_busy_ff)
   // the divider only runs for an outstanding masked query
   `BGR_ASSERT_SAME(a_div_pend, dv_busy_ff, pend_ff)
   // a started division is in progress next cycle
   `BGR_ASSERT_NEXT(a_div_start, dv_start, dv_busy_ff && !rsp_valid_ff)

endmodule
